// ----- rtl/i2cm_pkg.sv -----
`timescale 1ns / 1ps

package i2cm_pkg;

  // one request beat: register access or bus engine response
  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  reg_index;
    logic [31:0] wdata;
    logic        ack_in;
    logic [7:0]  rx_byte;
  } i2cm_in_t;

  // one response beat
  typedef struct packed {
    logic [31:0] rdata;
    logic [2:0]  bus_cmd;
    logic [7:0]  bus_byte;
    logic        send_nack;
    logic        irq;
  } i2cm_out_t;

  // request opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RESP  = 2'd2;

  // bus engine commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RECV  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  // register word indexes
  localparam logic [4:0] REG_TARGET       = 5'd0;
  localparam logic [4:0] REG_SEND_FIRST   = 5'd1;
  localparam logic [4:0] REG_SEND_LAST    = 5'd8;
  localparam logic [4:0] REG_COUNTS       = 5'd9;
  localparam logic [4:0] REG_CONTROL      = 5'd10;
  localparam logic [4:0] REG_ENABLE       = 5'd11;
  localparam logic [4:0] REG_RECV_FIRST   = 5'd12;
  localparam logic [4:0] REG_RECV_LAST    = 5'd19;
  localparam logic [4:0] REG_CONTROL_HIGH = 5'd20;

  // transfer formats, control bits 1:0
  localparam logic [1:0] FMT_WRITE       = 2'd0;
  localparam logic [1:0] FMT_READ        = 2'd1;
  localparam logic [1:0] FMT_READ_WRITE  = 2'd2;
  localparam logic [1:0] FMT_WRITE_READ  = 2'd3;

  // bit positions
  localparam int EN_ENABLE  = 0;
  localparam int EN_DONE    = 1;
  localparam int EN_NOACK   = 2;
  localparam int EN_NOSTOP  = 4;
  localparam int EN_NOSTART = 5;
  localparam int CTL_INTEN  = 6;
  localparam int CH_IGNACK  = 1;
  localparam int CH_WIDE    = 6;

  // sequencer phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_ADDR1   = 4'd2;
  localparam logic [3:0] PH_DATA1   = 4'd3;
  localparam logic [3:0] PH_RESTART = 4'd4;
  localparam logic [3:0] PH_ADDR2   = 4'd5;
  localparam logic [3:0] PH_DATA2   = 4'd6;
  localparam logic [3:0] PH_STOP    = 4'd7;
  localparam logic [3:0] PH_ERRSTOP = 4'd8;

endpackage

// ----- rtl/i2cm_seq.sv -----
`timescale 1ns / 1ps

module i2cm_seq import i2cm_pkg::*; #(
  parameter int FIFO_BYTES = 32,
  parameter int DATA_WORDS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  i2cm_in_t  item,
  output i2cm_out_t result
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam int WIDE_CAP = (FIFO_BYTES < 4 * DATA_WORDS) ? FIFO_BYTES : 4 * DATA_WORDS;
  localparam logic [5:0] WideBytes   = 6'(WIDE_CAP);
  localparam logic [5:0] NarrowBytes = 6'(DATA_WORDS);
  localparam logic [4:0] DataWords5  = 5'(DATA_WORDS);

  logic [7:0]  target_address, target_address_next;
  logic [11:0] phase_counts, phase_counts_next;
  logic [7:0]  control_word, control_word_next;
  logic [5:0]  enable_status, enable_status_next;
  logic [6:0]  control_high, control_high_next;
  logic [3:0]  phase, phase_next;
  logic [5:0]  byte_position, byte_position_next;
  logic [31:0] send_words [DATA_WORDS];
  logic [31:0] receive_words [DATA_WORDS];

  // register file side effects
  logic          sw_we;
  logic [AW-1:0] sw_idx;
  logic          rx_we;
  logic [AW-1:0] rx_idx;
  logic [3:0]    rx_lanes;
  logic [31:0]   rx_word;

  // transfer geometry
  logic       wide, two_phase, reads1, reads2;
  logic [5:0] cap, len1, len2;

  // next-data step, shared by start-up, address and data responses
  logic       nd_ph2, nd_nostop, nd_reads, nd_first_of_two;
  logic [5:0] nd_pos, nd_len, nd_pos_inc;
  logic [3:0] nd_phase;
  logic [2:0] nd_cmd;
  logic [7:0] nd_byte;
  logic       nd_nack, nd_done;
  logic [31:0] nd_word;

  logic       busy, nacked, cur_reads;
  logic [4:0] sw_off, rx_off;

  assign wide      = control_high[CH_WIDE];
  assign cap       = wide ? WideBytes : NarrowBytes;
  assign len1      = (phase_counts[5:0] < cap) ? phase_counts[5:0] : cap;
  assign len2      = (phase_counts[11:6] < cap) ? phase_counts[11:6] : cap;
  assign two_phase = control_word[1];
  assign reads1    = (control_word[1:0] == FMT_READ) || (control_word[1:0] == FMT_READ_WRITE);
  assign reads2    = (control_word[1:0] == FMT_WRITE_READ);
  assign busy      = (phase != PH_IDLE);
  assign nacked    = !item.ack_in && !control_high[CH_IGNACK];
  assign cur_reads = (phase == PH_DATA2) ? reads2 : reads1;

  assign nd_ph2 = (item.op == OP_RESP) && ((phase == PH_ADDR2) || (phase == PH_DATA2));
  assign nd_pos = ((item.op == OP_RESP) && ((phase == PH_DATA1) || (phase == PH_DATA2))) ?
                  6'(byte_position + 6'd1) : 6'd0;
  assign nd_nostop       = (item.op == OP_WRITE) ? item.wdata[EN_NOSTOP] : enable_status[EN_NOSTOP];
  assign nd_len          = nd_ph2 ? len2 : len1;
  assign nd_reads        = nd_ph2 ? reads2 : reads1;
  assign nd_first_of_two = !nd_ph2 && two_phase;
  assign nd_pos_inc      = 6'(nd_pos + 6'd1);
  assign nd_word         = wide ? send_words[nd_pos[AW+1:2]] : send_words[nd_pos[AW-1:0]];

  always_comb begin
    nd_phase = PH_IDLE;
    nd_cmd   = CMD_NONE;
    nd_byte  = 8'd0;
    nd_nack  = 1'b0;
    nd_done  = 1'b0;
    if (nd_pos < nd_len) begin
      nd_phase = nd_ph2 ? PH_DATA2 : PH_DATA1;
      if (nd_reads) begin
        nd_cmd  = CMD_RECV;
        nd_nack = (nd_pos_inc == nd_len) && (nd_first_of_two || !nd_nostop);
      end else begin
        nd_cmd = CMD_SEND;
        if (wide) begin
          case (nd_pos[1:0])
            2'd0:    nd_byte = nd_word[7:0];
            2'd1:    nd_byte = nd_word[15:8];
            2'd2:    nd_byte = nd_word[23:16];
            default: nd_byte = nd_word[31:24];
          endcase
        end else begin
          nd_byte = nd_word[7:0];
        end
      end
    end else if (nd_first_of_two) begin
      nd_phase = PH_RESTART;
      nd_cmd   = CMD_START;
    end else if (nd_nostop) begin
      nd_phase = PH_IDLE;
      nd_done  = 1'b1;
    end else begin
      nd_phase = PH_STOP;
      nd_cmd   = CMD_STOP;
    end
  end

  assign sw_off   = 5'(item.reg_index - REG_SEND_FIRST);
  assign rx_off   = 5'(item.reg_index - REG_RECV_FIRST);
  assign sw_idx   = sw_off[AW-1:0];
  assign rx_idx   = wide ? byte_position[AW+1:2] : byte_position[AW-1:0];
  assign rx_lanes = wide ? (4'b0001 << byte_position[1:0]) : 4'b1111;
  assign rx_word  = wide ? {4{item.rx_byte}} : {24'd0, item.rx_byte};

  always_comb begin
    target_address_next = target_address;
    phase_counts_next   = phase_counts;
    control_word_next   = control_word;
    enable_status_next  = enable_status;
    control_high_next   = control_high;
    phase_next          = phase;
    byte_position_next  = byte_position;
    sw_we               = 1'b0;
    rx_we               = 1'b0;
    result              = '0;

    unique case (item.op)
      OP_READ: begin
        unique case (item.reg_index) inside
          REG_TARGET:       result.rdata = {24'd0, target_address};
          REG_COUNTS:       result.rdata = {20'd0, phase_counts};
          REG_CONTROL:      result.rdata = {24'd0, control_word};
          REG_ENABLE:       result.rdata = {26'd0, enable_status};
          REG_CONTROL_HIGH: result.rdata = {25'd0, control_high};
          [REG_RECV_FIRST:REG_RECV_LAST]: begin
            if (rx_off < DataWords5) result.rdata = receive_words[rx_off[AW-1:0]];
          end
          default:          result.rdata = 32'd0;
        endcase
      end
      OP_WRITE: begin
        if (item.reg_index == REG_ENABLE) begin
          if (!(busy && item.wdata[EN_ENABLE])) begin
            enable_status_next = {item.wdata[EN_NOSTART], item.wdata[EN_NOSTOP], 3'b000,
                                  item.wdata[EN_ENABLE]};
            if (busy) begin
              phase_next         = PH_IDLE;
              byte_position_next = 6'd0;
            end
            // rising edge of enable kicks off a transfer
            if (!enable_status[EN_ENABLE] && item.wdata[EN_ENABLE]) begin
              byte_position_next = 6'd0;
              if (item.wdata[EN_NOSTART]) begin
                phase_next         = nd_phase;
                byte_position_next = nd_pos;
                result.bus_cmd     = nd_cmd;
                result.bus_byte    = nd_byte;
                result.send_nack   = nd_nack;
                if (nd_done) enable_status_next[EN_DONE] = 1'b1;
              end else begin
                phase_next     = PH_START;
                result.bus_cmd = CMD_START;
              end
            end
          end
        end else if (!busy) begin
          unique case (item.reg_index) inside
            REG_TARGET:       target_address_next = item.wdata[7:0];
            REG_COUNTS:       phase_counts_next   = item.wdata[11:0];
            REG_CONTROL:      control_word_next   = item.wdata[7:0];
            REG_CONTROL_HIGH: control_high_next   = item.wdata[6:0];
            [REG_SEND_FIRST:REG_SEND_LAST]: sw_we = (sw_off < DataWords5);
            default: ;
          endcase
        end
      end
      OP_RESP: begin
        if (busy) begin
          unique case (phase)
            PH_START: begin
              phase_next      = PH_ADDR1;
              result.bus_cmd  = CMD_SEND;
              result.bus_byte = {target_address[7:1], reads1};
            end
            PH_RESTART: begin
              phase_next      = PH_ADDR2;
              result.bus_cmd  = CMD_SEND;
              result.bus_byte = {target_address[7:1], reads2};
            end
            PH_ADDR1, PH_ADDR2, PH_DATA1, PH_DATA2: begin
              if ((phase == PH_DATA1) || (phase == PH_DATA2)) rx_we = cur_reads;
              if (nacked && !(((phase == PH_DATA1) || (phase == PH_DATA2)) && cur_reads)) begin
                enable_status_next[EN_NOACK] = 1'b1;
                phase_next                   = PH_ERRSTOP;
                result.bus_cmd               = CMD_STOP;
              end else begin
                phase_next         = nd_phase;
                byte_position_next = nd_pos;
                result.bus_cmd     = nd_cmd;
                result.bus_byte    = nd_byte;
                result.send_nack   = nd_nack;
                if (nd_done) enable_status_next[EN_DONE] = 1'b1;
              end
            end
            PH_STOP: begin
              enable_status_next[EN_DONE] = 1'b1;
              phase_next                  = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase

    result.irq = enable_status_next[EN_DONE] && control_word_next[CTL_INTEN];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= 8'd0;
      phase_counts   <= 12'd0;
      control_word   <= 8'd0;
      enable_status  <= 6'd0;
      control_high   <= 7'd0;
      phase          <= PH_IDLE;
      byte_position  <= 6'd0;
      for (int i = 0; i < DATA_WORDS; i++) receive_words[i] <= 32'd0;
    end else if (step) begin
      target_address <= target_address_next;
      phase_counts   <= phase_counts_next;
      control_word   <= control_word_next;
      enable_status  <= enable_status_next;
      control_high   <= control_high_next;
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      if (rx_we) begin
        for (int l = 0; l < 4; l++) begin
          if (rx_lanes[l]) receive_words[rx_idx][8*l +: 8] <= rx_word[8*l +: 8];
        end
      end
    end
  end

  // send words have no reset, contents undefined until written
  always_ff @(posedge clk) begin
    if (step && sw_we) send_words[sw_idx] <= item.wdata;
  end

endmodule

// ----- rtl/i2c_master_register_controller_core.sv -----
`timescale 1ns / 1ps

// i2c master controller behind a word-addressed register map
//
// req channel: one beat per register read, register write or bus engine
// response (start/stop done, byte sent with its ack, byte received).
// rsp channel: exactly one beat per request beat, in order, carrying the
// read data, the next bus engine command with its byte and nack flag, and
// the interrupt line as it stands after the request.
//
// a request beat lands in the input register, is decoded and applied to
// the register file and transfer sequencer, and its response is stored
// in the output register. throughput is one beat per cycle while rsp is
// not stalled; the single decode-and-update pass between the two registers
// sets that figure.
//
// when rsp is stalled the output register holds its beat, the input
// register still takes one more request, and req_stall rises only once
// both are full. synchronous reset clears all control registers, the
// receive words and the sequencer; send words stay undefined until written.

module i2c_master_register_controller_core import i2cm_pkg::*; #(
  parameter int FIFO_BYTES = 32,
  parameter int DATA_WORDS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  i2cm_in_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output i2cm_out_t rsp
);

  // input register
  logic      item_valid;
  i2cm_in_t  item;

  // decode and update happen when the input register holds a beat and the
  // output register is free or being emptied this cycle
  logic      out_free;
  logic      advance;
  i2cm_out_t result;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = item_valid && out_free;
  assign req_stall = item_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) item <= req;
  end

  i2cm_seq #(
    .FIFO_BYTES (FIFO_BYTES),
    .DATA_WORDS (DATA_WORDS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) rsp <= result;
  end

endmodule

// ----- rtl/i2cm_chk.sv -----
`timescale 1ns / 1ps

module i2cm_chk import i2cm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input i2cm_out_t rsp
);

  // response beat held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed while stalled");

  // no response beat right after reset
  a_rsp_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

  // empty output register never backs up the request side
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("req stalled with output register empty");

  // bus byte only travels with a send command
  a_byte_send: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.bus_cmd != CMD_SEND) |-> (rsp.bus_byte == 8'd0))
    else $error("bus byte without send command");

  // nack flag only on a receive, and read data never comes with a command
  a_nack_recv: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.send_nack || (rsp.rdata != 32'd0)) |->
      (rsp.send_nack ? (rsp.bus_cmd == CMD_RECV) : (rsp.bus_cmd == CMD_NONE)))
    else $error("nack or read data with wrong command");

endmodule

bind i2c_master_register_controller_core i2cm_chk u_chk (.*);

// ----- tb/i2c_master_register_controller_core_test.sv -----
`timescale 1ns / 1ps

module i2c_master_register_controller_core_test;
  import i2cm_pkg::*;

  localparam int FIFO_BYTES  = 32;
  localparam int DATA_WORDS  = 8;
  localparam int RANDOM_BEATS = 1700;
  localparam int NOISE_BEATS  = 100;
  localparam int STUCK_LIMIT  = 2000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  i2cm_in_t  req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  i2cm_out_t rsp;

  i2c_master_register_controller_core #(
    .FIFO_BYTES(FIFO_BYTES),
    .DATA_WORDS(DATA_WORDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  // shadow copy of the controller state
  logic [7:0]  tgt_addr;
  logic [11:0] counts_reg;
  logic [7:0]  ctl_reg;
  logic [5:0]  en_reg;
  logic [6:0]  ctlh_reg;
  logic [31:0] tx_words [DATA_WORDS];
  logic [31:0] rx_words [DATA_WORDS];
  logic [3:0]  seq_phase;
  logic [5:0]  byte_pos;
  i2cm_out_t   next_rsp;

  i2cm_out_t pending_rsp [$];
  i2cm_out_t rsp_want;
  int        error_count = 0;
  int        beats_sent = 0;
  int        stuck_cycles = 0;
  bit        quiet = 1'b0;

  // data buffer size for the current lane mode
  function automatic int buffer_bytes();
    if (ctlh_reg[CH_WIDE])
      return (FIFO_BYTES < 4 * DATA_WORDS) ? FIFO_BYTES : 4 * DATA_WORDS;
    return DATA_WORDS;
  endfunction

  function automatic int phase_bytes(input int ph);
    int n;
    int cap;
    n = (ph == 1) ? int'(counts_reg[5:0]) : int'(counts_reg[11:6]);
    cap = buffer_bytes();
    return (n < cap) ? n : cap;
  endfunction

  function automatic bit two_phase();
    return ctl_reg[1:0] == FMT_READ_WRITE || ctl_reg[1:0] == FMT_WRITE_READ;
  endfunction

  function automatic bit phase_reads(input int ph);
    if (ph == 1)
      return ctl_reg[1:0] == FMT_READ || ctl_reg[1:0] == FMT_READ_WRITE;
    return ctl_reg[1:0] == FMT_WRITE_READ;
  endfunction

  function automatic logic [7:0] tx_byte_at(input int pos);
    if (ctlh_reg[CH_WIDE])
      return 8'(tx_words[(pos >> 2) & 7] >> (8 * (pos & 3)));
    return tx_words[pos & 7][7:0];
  endfunction

  function automatic void send_addr(input int ph);
    seq_phase = (ph == 1) ? PH_ADDR1 : PH_ADDR2;
    next_rsp.bus_cmd = CMD_SEND;
    next_rsp.bus_byte = {tgt_addr[7:1], phase_reads(ph)};
  endfunction

  // next data byte of a phase, or what follows the phase
  function automatic void advance(input int ph, input int pos);
    int len;
    bit ends;
    len = phase_bytes(ph);
    byte_pos = 6'(pos);
    if (pos < len) begin
      seq_phase = (ph == 1) ? PH_DATA1 : PH_DATA2;
      if (phase_reads(ph)) begin
        // final byte is acked when no-stop leaves the bus held
        ends = (ph == 1 && two_phase()) || !en_reg[EN_NOSTOP];
        next_rsp.bus_cmd = CMD_RECV;
        next_rsp.send_nack = (pos + 1 == len) && ends;
      end else begin
        next_rsp.bus_cmd = CMD_SEND;
        next_rsp.bus_byte = tx_byte_at(pos);
      end
    end else if (ph == 1 && two_phase()) begin
      seq_phase = PH_RESTART;
      next_rsp.bus_cmd = CMD_START;
    end else if (en_reg[EN_NOSTOP]) begin
      seq_phase = PH_IDLE;
      en_reg[EN_DONE] = 1'b1;
    end else begin
      seq_phase = PH_STOP;
      next_rsp.bus_cmd = CMD_STOP;
    end
  endfunction

  // missing ack: flag it and stop even with no-stop
  function automatic void flag_nack();
    en_reg[EN_NOACK] = 1'b1;
    seq_phase = PH_ERRSTOP;
    next_rsp.bus_cmd = CMD_STOP;
  endfunction

  function automatic i2cm_out_t predict_beat(input i2cm_in_t b);
    bit busy;
    bit was_on;
    bit nacked;
    int ph;
    int w;
    int sh;
    next_rsp = '0;
    busy = seq_phase != PH_IDLE;
    case (b.op)
      OP_READ: begin
        if (b.reg_index == REG_TARGET) next_rsp.rdata = 32'(tgt_addr);
        else if (b.reg_index == REG_COUNTS) next_rsp.rdata = 32'(counts_reg);
        else if (b.reg_index == REG_CONTROL) next_rsp.rdata = 32'(ctl_reg);
        else if (b.reg_index == REG_ENABLE) next_rsp.rdata = 32'(en_reg);
        else if (b.reg_index >= REG_RECV_FIRST && b.reg_index <= REG_RECV_LAST)
          next_rsp.rdata = rx_words[int'(b.reg_index) - int'(REG_RECV_FIRST)];
        else if (b.reg_index == REG_CONTROL_HIGH) next_rsp.rdata = 32'(ctlh_reg);
      end
      OP_WRITE: begin
        if (b.reg_index == REG_ENABLE) begin
          // while busy only a write with enable clear gets through, as an abort
          if (!(busy && b.wdata[EN_ENABLE])) begin
            if (busy) begin
              seq_phase = PH_IDLE;
              byte_pos = '0;
            end
            was_on = en_reg[EN_ENABLE];
            en_reg = b.wdata[5:0] & 6'b110001;
            if (!was_on && b.wdata[EN_ENABLE]) begin
              byte_pos = '0;
              if (en_reg[EN_NOSTART]) begin
                advance(1, 0);
              end else begin
                seq_phase = PH_START;
                next_rsp.bus_cmd = CMD_START;
              end
            end
          end
        end else if (!busy) begin
          if (b.reg_index == REG_TARGET) tgt_addr = b.wdata[7:0];
          else if (b.reg_index >= REG_SEND_FIRST && b.reg_index <= REG_SEND_LAST)
            tx_words[int'(b.reg_index) - int'(REG_SEND_FIRST)] = b.wdata;
          else if (b.reg_index == REG_COUNTS) counts_reg = b.wdata[11:0];
          else if (b.reg_index == REG_CONTROL) ctl_reg = b.wdata[7:0];
          else if (b.reg_index == REG_CONTROL_HIGH) ctlh_reg = b.wdata[6:0];
        end
      end
      OP_RESP: begin
        if (busy) begin
          nacked = !b.ack_in && !ctlh_reg[CH_IGNACK];
          ph = (seq_phase == PH_DATA1 || seq_phase == PH_ADDR1) ? 1 : 2;
          case (seq_phase)
            PH_START: send_addr(1);
            PH_RESTART: send_addr(2);
            PH_ADDR1, PH_ADDR2: begin
              if (nacked) flag_nack();
              else advance(ph, 0);
            end
            PH_DATA1, PH_DATA2: begin
              if (phase_reads(ph)) begin
                if (ctlh_reg[CH_WIDE]) begin
                  w = (int'(byte_pos) >> 2) & 7;
                  sh = 8 * (int'(byte_pos) & 3);
                  rx_words[w] = (rx_words[w] & ~(32'hFF << sh)) | (32'(b.rx_byte) << sh);
                end else begin
                  rx_words[int'(byte_pos) & 7] = 32'(b.rx_byte);
                end
                advance(ph, int'(byte_pos) + 1);
              end else if (nacked) begin
                flag_nack();
              end else begin
                advance(ph, int'(byte_pos) + 1);
              end
            end
            PH_STOP: begin
              en_reg[EN_DONE] = 1'b1;
              seq_phase = PH_IDLE;
            end
            default: seq_phase = PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
    next_rsp.irq = en_reg[EN_DONE] && ctl_reg[CTL_INTEN];
    return next_rsp;
  endfunction

  initial begin
    tgt_addr = '0;
    counts_reg = '0;
    ctl_reg = '0;
    en_reg = '0;
    ctlh_reg = '0;
    for (int i = 0; i < DATA_WORDS; i++) begin
      tx_words[i] = '0;
      rx_words[i] = '0;
    end
    seq_phase = PH_IDLE;
    byte_pos = '0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    error_count++;
  endtask

  // one request beat, with a random gap in front of it
  task automatic send_beat(input i2cm_in_t b);
    if (!quiet && $urandom_range(99) < 9) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= b;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(predict_beat(b));
    beats_sent++;
  endtask

  // unused fields carry random bits
  function automatic i2cm_in_t random_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(i2cm_in_t)-1:0];
  endfunction

  task automatic write_reg(input logic [4:0] idx, input logic [31:0] d);
    i2cm_in_t b;
    b = random_beat();
    b.op = OP_WRITE;
    b.reg_index = idx;
    b.wdata = d;
    send_beat(b);
  endtask

  task automatic read_reg(input logic [4:0] idx);
    i2cm_in_t b;
    b = random_beat();
    b.op = OP_READ;
    b.reg_index = idx;
    send_beat(b);
  endtask

  task automatic respond(input logic ack, input logic [7:0] rx);
    i2cm_in_t b;
    b = random_beat();
    b.op = OP_RESP;
    b.ack_in = ack;
    b.rx_byte = rx;
    send_beat(b);
  endtask

  // hold off the sender until every response has come back
  task automatic wait_for_responses();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly short phases, sometimes past the buffer size
  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 6'd0;
    if (r < 70) return 6'($urandom_range(1, 4));
    if (r < 90) return 6'($urandom_range(5, 12));
    return 6'($urandom_range(13, 63));
  endfunction

  task automatic test_register_map();
    i2cm_in_t b;
    read_reg(REG_ENABLE);
    read_reg(REG_RECV_FIRST);
    // every send word gets a value before any transfer can use it
    for (int i = 0; i < DATA_WORDS; i++)
      write_reg(5'(int'(REG_SEND_FIRST) + i),
                (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 : $urandom);
    write_reg(REG_TARGET, 32'hFFFF_FFFF);
    write_reg(REG_COUNTS, 32'hFFFF_FFFF);
    write_reg(REG_CONTROL, 32'hFFFF_FFFF);
    write_reg(REG_CONTROL_HIGH, 32'hFFFF_FFFF);
    read_reg(REG_TARGET);
    read_reg(REG_COUNTS);
    read_reg(REG_CONTROL_HIGH);
    read_reg(REG_SEND_LAST);
    read_reg(5'd31);
    // undefined opcode is ignored
    b = random_beat();
    b.op = 2'd3;
    send_beat(b);
  endtask

  task automatic test_nack_and_abort();
    write_reg(REG_TARGET, 32'h0000_00A5);
    write_reg(REG_COUNTS, 32'h0000_0001);
    write_reg(REG_CONTROL, (32'h1 << CTL_INTEN) | 32'(FMT_WRITE));
    write_reg(REG_CONTROL_HIGH, 32'h0);
    write_reg(REG_ENABLE, 32'h0);
    write_reg(REG_ENABLE, 32'h1 << EN_ENABLE);
    respond(1'b1, 8'h00);   // start done, address goes out
    respond(1'b0, 8'hFF);   // address not acked, error stop
    respond(1'b1, 8'h00);   // stop done, no done flag
    write_reg(REG_ENABLE, 32'h0);
    write_reg(REG_ENABLE, 32'h1 << EN_ENABLE);
    write_reg(REG_ENABLE, 32'h0);  // abort while the start is pending
    read_reg(REG_ENABLE);
  endtask

  // one well-formed transfer with random settings and random chatter
  task automatic run_transfer();
    logic [31:0] d;
    int pick;
    if ($urandom_range(3) == 0) write_reg(REG_TARGET, $urandom);
    d = $urandom;
    d[5:0] = pick_count();
    d[11:6] = pick_count();
    write_reg(REG_COUNTS, d);
    d = $urandom;
    write_reg(REG_CONTROL, d);
    d = $urandom;
    d[CH_IGNACK] = $urandom_range(3) == 0;
    write_reg(REG_CONTROL_HIGH, d);
    if ($urandom_range(3) == 0)
      write_reg(5'(int'(REG_SEND_FIRST) + $urandom_range(DATA_WORDS - 1)), $urandom);
    d = $urandom;
    d[EN_ENABLE] = 1'b0;
    d[EN_NOSTOP] = $urandom_range(3) == 0;
    d[EN_NOSTART] = $urandom_range(3) == 0;
    write_reg(REG_ENABLE, d);
    d[EN_ENABLE] = 1'b1;
    write_reg(REG_ENABLE, d);
    while (seq_phase != PH_IDLE) begin
      pick = $urandom_range(99);
      if (pick < 84) begin
        respond($urandom_range(99) < 97, 8'($urandom));
      end else if (pick < 94) begin
        read_reg(5'($urandom_range(31)));
      end else if (pick < 97) begin
        write_reg(5'($urandom_range(31)), $urandom);
      end else if (pick < 99) begin
        d = $urandom;
        d[EN_ENABLE] = 1'b1;
        write_reg(REG_ENABLE, d);   // ignored while busy
      end else begin
        d = $urandom;
        d[EN_ENABLE] = 1'b0;
        write_reg(REG_ENABLE, d);   // abort
      end
    end
    read_reg(REG_ENABLE);
    read_reg(5'(int'(REG_RECV_FIRST) + $urandom_range(DATA_WORDS - 1)));
    read_reg(5'(int'(REG_RECV_FIRST) + $urandom_range(DATA_WORDS - 1)));
  endtask

  task automatic test_random_transfers();
    int n;
    n = 0;
    while (beats_sent < RANDOM_BEATS) begin
      // a stretch with no gaps or stalls on either side
      quiet = beats_sent >= 700 && beats_sent < 950;
      run_transfer();
      n++;
      if (n % 25 == 0) wait_for_responses();
    end
    quiet = 1'b0;
  endtask

  // fully random beats, then bring any transfer they started to an end
  task automatic test_random_noise();
    for (int i = 0; i < NOISE_BEATS; i++)
      send_beat(random_beat());
    while (seq_phase != PH_IDLE)
      respond(1'b1, 8'($urandom));
  endtask

  // response side: random stalls, each accepted beat checked in order
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected beat", 32'(rsp.bus_cmd), 32'(CMD_NONE));
      end else begin
        rsp_want = pending_rsp.pop_front();
        if (rsp.rdata !== rsp_want.rdata)
          report_mismatch("rdata", rsp.rdata, rsp_want.rdata);
        if (rsp.bus_cmd !== rsp_want.bus_cmd)
          report_mismatch("bus_cmd", 32'(rsp.bus_cmd), 32'(rsp_want.bus_cmd));
        if (rsp.bus_byte !== rsp_want.bus_byte)
          report_mismatch("bus_byte", 32'(rsp.bus_byte), 32'(rsp_want.bus_byte));
        if (rsp.send_nack !== rsp_want.send_nack)
          report_mismatch("send_nack", 32'(rsp.send_nack), 32'(rsp_want.send_nack));
        if (rsp.irq !== rsp_want.irq)
          report_mismatch("irq", 32'(rsp.irq), 32'(rsp_want.irq));
      end
    end
    rsp_stall <= !quiet && ($urandom_range(99) < 9);
  end

  // no beat moving on either channel for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_register_map();
    test_nack_and_abort();
    wait_for_responses();
    test_random_transfers();
    test_random_noise();
    wait_for_responses();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
